// ===== rtl/core/emsm_pkg.sv =====
// Package with shared types, constants and codes of the encoder speed meter.
`default_nettype none
package emsm_pkg;
  localparam int Channels = 4;
  localparam int ChW = 2;
  localparam logic [22:0] RpmScale = 23'd6000000;

  localparam logic [1:0] OP_FALL = 2'd0;
  localparam logic [1:0] OP_RISE = 2'd1;
  localparam logic [1:0] OP_OVF  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [1:0] REG_PPR = 2'd0;
  localparam logic [1:0] REG_CHN = 2'd1;
  localparam logic [1:0] REG_INV = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd3;

  typedef struct packed {
    logic [31:0] window_count;
    logic [15:0] first_edge_time;
    logic [15:0] last_edge_time;
    logic [1:0]  last_direction;
    logic        edge_seen;
    logic [15:0] period_cap;
    logic [15:0] overflow_count;
    logic [31:0] last_edge_stamp;
  } chan_state_t;

  // The first word field sits in the lowest bits, so it is the last member.
  typedef struct packed {
    logic [15:0] captured_period;
    logic [15:0] timer_count;
    logic        b_level;
    logic [1:0]  channel;
    logic [1:0]  opcode;
  } event_t;
endpackage
`default_nettype wire

// ===== rtl/core/encoder_mt_speed_meter.sv =====
// Top level of the four-channel M/T encoder speed meter.
//
// Event words enter on s_axis (opcode, channel, B level, timer count,
// captured period). Edge and overflow words update the channel record
// and return no word. A window read returns one word on m_axis with the
// signed speed in RPM and a flag that an edge arrived in the window.
// Per-channel state lives in one memory with a registered read. Each word
// is read, updated and written back, and one word is handled at a time.
// Edge and overflow words pass the read and update states. A read then
// goes through a multiply of the time by the pulses-per-revolution
// setting and a restoring division of count*6000000 by that product,
// and then an output state.
// After reset the block sweeps the 4 memory entries to zero and accepts
// no word meanwhile. The result sits in an output register; a stalled
// receiver holds it, and no word of any kind is accepted until it is
// taken.
`default_nettype none
module encoder_mt_speed_meter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[1:0], channel[3:2], b_level[4], timer_count[20:5],
  // captured_period[36:21], zeros[39:37]
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // speed_rpm[31:0]
  output logic [31:0]      m_axis_tdata,
  // had edge flag
  output logic             m_axis_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  emsm_pkg::chan_state_t mem [emsm_pkg::Channels];
  emsm_pkg::chan_state_t rd_data;
  emsm_pkg::chan_state_t wr_data;
  logic                  wr_en;
  logic [emsm_pkg::ChW-1:0] wr_addr;

  logic [15:0] ppr_reg;
  logic [2:0]  channels_in_use;
  logic [3:0]  direction_invert;

  logic [2:0]  state;
  logic [emsm_pkg::ChW:0] clr_cnt;
  emsm_pkg::event_t ev;
  logic        neg;
  logic        zero_out;
  logic        had;
  logic [47:0] den;
  logic [31:0] mcand;
  logic [15:0] mplier;
  logic [54:0] num;
  logic [47:0] rem;
  logic [54:0] quo;
  logic [5:0]  step;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppr_reg <= 16'd520;
      channels_in_use <= 3'd4;
      direction_invert <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        emsm_pkg::REG_PPR: ppr_reg <= cfg_data;
        emsm_pkg::REG_CHN: channels_in_use <= cfg_data[2:0];
        emsm_pkg::REG_INV: direction_invert <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[ev.channel];
  end

  // Update of the record for edge, overflow and read words.
  logic        fwd;
  logic [31:0] now;
  logic [31:0] since;
  logic [31:0] mag;
  logic [15:0] span;
  logic [31:0] t_sel;
  logic        active;
  logic [31:0] pmax;
  emsm_pkg::chan_state_t upd;

  always_comb begin
    active = ({1'b0, ev.channel} < channels_in_use);
    fwd = (ev.opcode == emsm_pkg::OP_FALL) ? ev.b_level : !ev.b_level;
    if (direction_invert[ev.channel]) fwd = !fwd;
    now = {rd_data.overflow_count, ev.timer_count};
    since = now - rd_data.last_edge_stamp;
    mag = rd_data.window_count[31] ? (32'd0 - rd_data.window_count) : rd_data.window_count;
    span = rd_data.last_edge_time - rd_data.first_edge_time;
    pmax = (rd_data.period_cap == 16'd0) ? 32'd1 : {16'd0, rd_data.period_cap};
    if (mag >= 32'd2) t_sel = (span == 16'd0) ? 32'd65536 : {16'd0, span};
    else if (mag == 32'd1) begin
      if (rd_data.period_cap != 16'd0) t_sel = {16'd0, rd_data.period_cap};
      else t_sel = (since == 32'd0) ? 32'd1 : since;
    end else t_sel = (since > pmax) ? since : pmax;
    upd = rd_data;
    case (ev.opcode)
      emsm_pkg::OP_OVF: upd.overflow_count = rd_data.overflow_count + 16'd1;
      emsm_pkg::OP_READ: begin
        upd.window_count = 32'd0;
        upd.edge_seen = 1'b0;
      end
      default: begin
        upd.window_count = rd_data.window_count + (fwd ? 32'd1 : 32'hFFFF_FFFF);
        if (!rd_data.edge_seen) begin
          upd.first_edge_time = ev.timer_count;
          upd.edge_seen = 1'b1;
        end
        upd.last_edge_time = ev.timer_count;
        upd.last_edge_stamp = now;
        upd.last_direction = fwd ? emsm_pkg::DIR_FWD : emsm_pkg::DIR_REV;
        if (ev.opcode == emsm_pkg::OP_RISE) upd.period_cap = ev.captured_period;
      end
    endcase
  end

  logic [48:0] trial;
  assign trial = {rem, num[54]} - {1'b0, den};

  always_comb begin
    wr_en = 1'b0;
    wr_addr = ev.channel;
    wr_data = upd;
    if (state == S_CLR) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt[emsm_pkg::ChW-1:0];
      wr_data = '0;
    end else if (state == S_UPD && active) wr_en = 1'b1;
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + (emsm_pkg::ChW+1)'(1);
          if (clr_cnt == (emsm_pkg::ChW+1)'(emsm_pkg::Channels - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          ev <= s_axis_tdata[36:0];
          state <= S_RD;
        end
        S_RD: state <= S_UPD;
        S_UPD: begin
          if (ev.opcode != emsm_pkg::OP_READ) state <= S_IDLE;
          else begin
            had <= active && rd_data.edge_seen;
            zero_out <= !active || ppr_reg == 16'd0 ||
                        (mag == 32'd0 && rd_data.last_direction == emsm_pkg::DIR_NONE);
            if (mag == 32'd0) begin
              neg <= rd_data.last_direction == emsm_pkg::DIR_REV;
              num <= {32'd0, emsm_pkg::RpmScale};
            end else begin
              neg <= rd_data.window_count[31];
              num <= 55'(mag) * 55'(emsm_pkg::RpmScale);
            end
            mcand <= t_sel;
            mplier <= ppr_reg;
            den <= '0;
            step <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          den <= {den[46:0], 1'b0} + (mplier[15] ? {16'd0, mcand} : 48'd0);
          mplier <= {mplier[14:0], 1'b0};
          if (step == 6'd15) begin
            step <= '0;
            rem <= '0;
            state <= S_DIV;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_DIV: begin
          if (!trial[48]) begin
            rem <= trial[47:0];
            quo <= {quo[53:0], 1'b1};
          end else begin
            rem <= {rem[46:0], num[54]};
            quo <= {quo[53:0], 1'b0};
          end
          num <= {num[53:0], 1'b0};
          step <= step + 6'd1;
          if (step == 6'd54) state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tuser <= had;
          if (zero_out) m_axis_tdata <= 32'd0;
          else if (!neg) m_axis_tdata <= (quo > 55'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
          else m_axis_tdata <= (quo > 55'h8000_0000) ? 32'h8000_0000 : 32'd0 - quo[31:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/emsm_checker.sv =====
// Port-level checker of the encoder speed meter and its bind.
`default_nettype none
module emsm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result word changed while stalled");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result waits");
  a_one_per_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("two words taken back to back");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("activity right after reset");
endmodule
bind encoder_mt_speed_meter emsm_checker u_emsm_checker (.*);
`default_nettype wire

// ===== test/encoder_mt_speed_meter_tb.sv =====
// Self-checking testbench for the encoder speed meter with directed and random words.
`default_nettype none
module encoder_mt_speed_meter_tb;
  localparam int CycleLimit = 1000000;
  localparam int IdleWait = 100;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  encoder_mt_speed_meter dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [31:0] rpm;
    logic        edge_flag;
  } speed_t;

  // Predictor state and configuration.
  logic [15:0] ppr_cfg;
  logic [2:0]  chn_cfg;
  logic [3:0]  inv_cfg;
  logic [31:0] win_cnt [emsm_pkg::Channels];
  logic [15:0] first_t [emsm_pkg::Channels];
  logic [15:0] last_t [emsm_pkg::Channels];
  logic [1:0]  prev_dir [emsm_pkg::Channels];
  logic        seen [emsm_pkg::Channels];
  logic [15:0] period [emsm_pkg::Channels];
  logic [15:0] ovf_cnt [emsm_pkg::Channels];
  logic [31:0] edge_stamp [emsm_pkg::Channels];

  speed_t speed_q[$];
  speed_t forced_q[$];
  logic   use_forced;
  int     errors = 0;
  int     words_sent = 0;
  int     speeds_seen = 0;
  int     cycles = 0;
  int     burst_left = 1;
  int     stall_mode = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] scaled_div(input logic neg, input logic [63:0] mag,
                                             input logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return 32'd0;
    q = (mag * 64'd6000000) / den;
    if (!neg) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return 32'd0 - q[31:0];
  endfunction

  task automatic predict_speed(input logic [39:0] w, output logic produced, output speed_t s);
    logic [1:0]  op;
    logic [1:0]  c;
    logic        b;
    logic [15:0] tm;
    logic [15:0] cap;
    logic        active;
    logic        fwd;
    logic [31:0] m;
    logic        neg;
    logic [63:0] mag;
    logic [31:0] since;
    logic [31:0] span;
    logic [31:0] tb;
    op = w[1:0];
    c = w[3:2];
    b = w[4];
    tm = w[20:5];
    cap = w[36:21];
    active = (c < chn_cfg) && (c < emsm_pkg::Channels);
    produced = 1'b0;
    s.rpm = 32'd0;
    s.edge_flag = 1'b0;
    if (op != emsm_pkg::OP_READ) begin
      if (!active) return;
      if (op == emsm_pkg::OP_OVF) begin
        ovf_cnt[c] = ovf_cnt[c] + 16'd1;
      end else begin
        fwd = (op == emsm_pkg::OP_FALL) ? b : !b;
        if (inv_cfg[c]) fwd = !fwd;
        win_cnt[c] = win_cnt[c] + (fwd ? 32'd1 : 32'hFFFF_FFFF);
        if (!seen[c]) begin
          first_t[c] = tm;
          seen[c] = 1'b1;
        end
        last_t[c] = tm;
        edge_stamp[c] = {ovf_cnt[c], tm};
        prev_dir[c] = fwd ? emsm_pkg::DIR_FWD : emsm_pkg::DIR_REV;
        if (op == emsm_pkg::OP_RISE) period[c] = cap;
      end
      return;
    end
    produced = 1'b1;
    if (!active) return;
    m = win_cnt[c];
    neg = m[31];
    mag = neg ? {32'd0, 32'd0 - m} : {32'd0, m};
    since = {ovf_cnt[c], tm} - edge_stamp[c];
    s.edge_flag = seen[c];
    win_cnt[c] = 32'd0;
    seen[c] = 1'b0;
    if (mag >= 2) begin
      span = {16'd0, last_t[c] - first_t[c]};
      if (span == 0) span = 32'd65536;
      s.rpm = scaled_div(neg, mag, {32'd0, span} * ppr_cfg);
    end else if (mag == 1) begin
      tb = {16'd0, period[c]};
      if (tb == 0) tb = (since == 0) ? 32'd1 : since;
      s.rpm = scaled_div(neg, 64'd1, {32'd0, tb} * ppr_cfg);
    end else if (prev_dir[c] != emsm_pkg::DIR_NONE) begin
      tb = (period[c] == 0) ? 32'd1 : {16'd0, period[c]};
      if (since > tb) tb = since;
      s.rpm = scaled_div(prev_dir[c] == emsm_pkg::DIR_REV, 64'd1, {32'd0, tb} * ppr_cfg);
    end
  endtask

  // Input monitor and output checker.
  always @(posedge clk) begin
    logic   produced;
    speed_t s;
    speed_t e;
    speed_t f;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      speeds_seen++;
      if (speed_q.size() == 0) begin
        $display("%0t: unexpected speed word %0d edge %0b", $time,
                 $signed(m_axis_tdata), m_axis_tuser);
        errors++;
      end else begin
        e = speed_q.pop_front();
        if (m_axis_tdata !== e.rpm || m_axis_tuser !== e.edge_flag) begin
          $display("%0t: speed mismatch: expected %0d edge %0b, actual %0d edge %0b", $time,
                   $signed(e.rpm), e.edge_flag, $signed(m_axis_tdata), m_axis_tuser);
          errors++;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_speed(s_axis_tdata, produced, s);
      if (produced) begin
        if (use_forced && forced_q.size() > 0) begin
          f = forced_q.pop_front();
          speed_q.push_back(f);
        end else begin
          speed_q.push_back(s);
        end
      end
    end
  end

  // Receiver stalls in changing patterns.
  always @(posedge clk) begin
    cycles++;
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 15) != 0);
    endcase
    if (cycles > CycleLimit) begin
      $display("encoder_mt_speed_meter test failed");
      $finish;
    end
  end

  function automatic logic [39:0] pack_word(input logic [1:0] op, input logic [1:0] ch,
                                            input logic b, input logic [15:0] tm,
                                            input logic [15:0] cap);
    return {3'b000, cap, tm, b, ch, op};
  endfunction

  task automatic send_word(input logic [39:0] w);
    int gap;
    s_axis_tdata <= w;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = $urandom_range(1, 12);
    while (speed_q.size() > 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] ppr, input logic [2:0] chn,
                            input logic [3:0] inv);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= emsm_pkg::REG_PPR;
    cfg_data <= ppr;
    @(posedge clk);
    cfg_index <= emsm_pkg::REG_CHN;
    cfg_data <= {13'd0, chn};
    @(posedge clk);
    cfg_index <= emsm_pkg::REG_INV;
    cfg_data <= {12'd0, inv};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    ppr_cfg = ppr;
    chn_cfg = chn;
    inv_cfg = inv;
  endtask

  task automatic run_episode();
    logic [1:0]  ch;
    logic [1:0]  op;
    logic [15:0] tm;
    logic [15:0] cap;
    logic        fwd;
    logic        b;
    int          n;
    ch = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 6) == 0) begin
      send_word(pack_word(2'($urandom_range(0, 3)), ch, 1'($urandom_range(0, 1)),
                          16'($urandom), 16'($urandom)));
      return;
    end
    n = $urandom_range(0, 6);
    fwd = $urandom_range(0, 3) != 0;
    tm = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 1) ? emsm_pkg::OP_FALL : emsm_pkg::OP_RISE;
      b = (op == emsm_pkg::OP_FALL) ? fwd : !fwd;
      if ($urandom_range(0, 4) == 0) b = 1'($urandom_range(0, 1));
      tm = tm + 16'($urandom_range(0, 3000));
      cap = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        send_word(pack_word(emsm_pkg::OP_OVF, ch, 1'b0, tm, 16'd0));
      end
      send_word(pack_word(op, ch, b, tm, cap));
    end
    tm = tm + 16'($urandom_range(0, 20000));
    send_word(pack_word(emsm_pkg::OP_READ, ch, 1'($urandom_range(0, 1)), tm, 16'($urandom)));
  endtask

  task automatic saturate(input logic b);
    send_word(pack_word(emsm_pkg::OP_FALL, 2'd0, b, 16'd0, 16'd0));
    for (int i = 0; i < 359; i++) begin
      send_word(pack_word(emsm_pkg::OP_FALL, 2'd0, b, 16'd1, 16'd0));
    end
    send_word(pack_word(emsm_pkg::OP_READ, 2'd0, 1'b0, 16'd1, 16'd0));
  endtask

  typedef struct {
    logic [39:0] w;
    logic        known;
    speed_t      s;
  } stim_row_t;

  stim_row_t rows[$];

  initial begin
    logic [15:0] ppr_list [6];
    logic [2:0]  chn_list [6];
    logic [3:0]  inv_list [6];
    int          target;
    ppr_list = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd100, 16'd520};
    chn_list = '{3'd4, 3'd1, 3'd3, 3'd0, 3'd7, 3'd2};
    inv_list = '{4'hF, 4'hA, 4'h5, 4'h3, 4'h2, 4'h0};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = emsm_pkg::REG_PPR;
    cfg_data = '0;
    use_forced = 1'b0;
    ppr_cfg = 16'd520;
    chn_cfg = 3'd4;
    inv_cfg = 4'd0;
    for (int c = 0; c < emsm_pkg::Channels; c++) begin
      win_cnt[c] = '0; first_t[c] = '0; last_t[c] = '0; prev_dir[c] = emsm_pkg::DIR_NONE;
      seen[c] = 1'b0; period[c] = '0; ovf_cnt[c] = '0; edge_stamp[c] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    rows = '{
      '{pack_word(emsm_pkg::OP_READ, 2'd0, 1'b0, 16'd0, 16'd0), 1'b1, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF), 1'b1, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_FALL, 2'd0, 1'b1, 16'd100, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_FALL, 2'd0, 1'b1, 16'd1100, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd0, 1'b0, 16'd1200, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd0, 1'b0, 16'd1300, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_RISE, 2'd1, 1'b0, 16'hFFFF, 16'hFFFF), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd1, 1'b0, 16'd0, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_RISE, 2'd2, 1'b1, 16'd5, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_OVF, 2'd2, 1'b0, 16'd0, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd2, 1'b0, 16'd5, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_FALL, 2'd3, 1'b0, 16'd7, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_FALL, 2'd3, 1'b0, 16'd7, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd3, 1'b0, 16'd7, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_FALL, 2'd1, 1'b1, 16'd10, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_RISE, 2'd1, 1'b1, 16'd10, 16'd3), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd1, 1'b0, 16'd10, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd2, 1'b0, 16'hFFFF, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_FALL, 2'd0, 1'b0, 16'h1234, 16'd0), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_RISE, 2'd0, 1'b0, 16'h1235, 16'h8000), 1'b0, '{32'd0, 1'b0}},
      '{pack_word(emsm_pkg::OP_READ, 2'd0, 1'b1, 16'h1236, 16'hFFFF), 1'b0, '{32'd0, 1'b0}}
    };
    // Rows with a typed expectation override the predicted value.
    foreach (rows[i]) begin
      if (rows[i].known) begin
        forced_q.push_back(rows[i].s);
        use_forced = 1'b1;
      end
      send_word(rows[i].w);
      if (rows[i].known) begin
        s_axis_tvalid <= 1'b0;
        burst_left = $urandom_range(1, 12);
        @(posedge clk);
        use_forced = 1'b0;
      end
    end

    for (int p = 0; p < 6; p++) begin
      write_regs(ppr_list[p], chn_list[p], inv_list[p]);
      if (p == 0) saturate(1'b0);
      target = words_sent + 60;
      while (words_sent < target) run_episode();
    end

    drain();
    $display("Sent %0d event words over 6 register settings; %0d speed words checked.",
             words_sent, speeds_seen);
    $display("Covered positive saturation, idle channels, zero pulses per rev and decay.");
    if (errors == 0) begin
      $display("encoder_mt_speed_meter test passed");
    end else begin
      $display("encoder_mt_speed_meter test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
